@@ src/tvdsl_pkg.sv @@
// tvdsl_pkg: shared types and constants for the TVD slope limiter.
// No dependencies; imported by the limiter top level, the checker and the testbench.
`timescale 1ns / 1ps

package tvdsl_pkg;

  // How the final limiter value is formed at the select stage
  typedef enum logic [1:0] {
    LIM_ZERO,   // non-positive ratio
    LIM_ONE,    // flat region, limiter is exactly 1.0
    LIM_QUOT,   // quotient from the divider alone
    LIM_MIN     // min(quotient, (1+2r)/3, 1.0)
  } lim_sel_t;

  localparam int unsigned LIM_SEL_W = 2;

  // Configuration register map
  localparam int unsigned CFG_ADDR_W      = 2;
  localparam int unsigned CFG_DATA_W      = 32;
  localparam logic [CFG_ADDR_W-1:0] ADDR_LIMIT_MODE = 2'd0;

  typedef enum logic {
    MODE_RS_CAP = 1'b0,   // cap with 4/(1+r)
    MODE_NO_RS  = 1'b1    // cap with (1+2r)/3
  } limit_mode_t;

endpackage

@@ src/tvd_slope_limiter_unit.sv @@
// tvd_slope_limiter_unit: TVD slope limiter top level, fixed point.
// Depends on tvdsl_pkg and tvdsl_div.
`timescale 1ns / 1ps
//
//  Channel   Ports          Direction  Carries
//  in_       tvalid/tready  slave      slope_ratio, gradient_in
//  out_      tvalid/tready  master     gradient_out, limiter_value
//  cfg_      APB            slave      limit_mode register at byte address 0
//
//  The pipeline has three entry stages, one divider stage per quotient bit
//  (FRAC_BITS + 2), then select, multiply, sum and the output register.
//  One transaction per cycle is sustained while out_tready is high.
//  rst_n is synchronous; it empties the pipeline and clears limit_mode.
//  A stall only holds stages that are full, so bubbles still close up and
//  input is taken while a result waits at the output.

module tvd_slope_limiter_unit #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // slope_ratio [DATA_WIDTH-1:0], gradient_in [2*DATA_WIDTH-1:DATA_WIDTH]
  input  logic [((2*DATA_WIDTH+7)/8)*8-1:0] in_tdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // gradient_out [DATA_WIDTH-1:0], limiter_value [DATA_WIDTH+FRAC_BITS:DATA_WIDTH]
  output logic [((DATA_WIDTH+FRAC_BITS+1+7)/8)*8-1:0] out_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [tvdsl_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [tvdsl_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [tvdsl_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                   cfg_pready
);

  import tvdsl_pkg::*;

  localparam int DW     = DATA_WIDTH;
  localparam int LIM_W  = FRAC_BITS + 1;
  localparam int QW     = FRAC_BITS + 2;
  localparam int HW     = DATA_WIDTH / 2;
  localparam int SIDE_W = LIM_W + LIM_SEL_W + 1 + DW;
  localparam int OUT_W  = ((DATA_WIDTH+FRAC_BITS+1+7)/8)*8;
  localparam int RSH    = FRAC_BITS + 4;   // shift of the divide-by-3 reciprocal

  localparam logic [DW+1:0]  ONE_X  = (DW+2)'(1) << FRAC_BITS;
  localparam logic [DW+1:0]  THREE_X = ONE_X + (ONE_X << 1);
  localparam logic [DW-1:0]  ONE_D  = DW'(1) << FRAC_BITS;
  localparam logic [QW-1:0]  ONE_Q  = QW'(1) << FRAC_BITS;
  localparam logic [LIM_W-1:0] ONE_L = LIM_W'(1) << FRAC_BITS;
  localparam logic [RSH:0]   POW_R  = (RSH+1)'(1) << RSH;
  localparam logic [RSH:0]   RECIP_W = POW_R / 3;
  localparam logic [QW:0]    RECIP3 = RECIP_W[QW:0];

  // ---------------- configuration ----------------
  logic mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RS_CAP;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      mode_r <= cfg_pwdata[0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ADDR_LIMIT_MODE) ? CFG_DATA_W'(mode_r) : '0;

  // ---------------- handshake chain ----------------
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;
  logic div_in_ready, div_out_valid;

  assign rdy7 = !v7_r || out_tready;
  assign rdy6 = !v6_r || rdy7;
  assign rdy5 = !v5_r || rdy6;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || div_in_ready;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= div_out_valid;
      if (rdy5) v5_r <= v4_r;
      if (rdy6) v6_r <= v5_r;
      if (rdy7) v7_r <= v6_r;
    end
  end

  // ---------------- stage 1: magnitudes ----------------
  logic [DW-1:0] slope_in, grad_in;
  logic [DW-1:0] r_mag_nxt, g_mag_nxt;
  logic [DW-1:0] r_mag1_r, g_mag1_r;
  logic          r_neg1_r, g_neg1_r, mode1_r;

  assign slope_in  = in_tdata[DW-1:0];
  assign grad_in   = in_tdata[2*DW-1:DW];
  assign r_mag_nxt = slope_in[DW-1] ? (~slope_in + 1'b1) : slope_in;
  assign g_mag_nxt = grad_in[DW-1]  ? (~grad_in + 1'b1)  : grad_in;

  always_ff @(posedge clk) begin
    if (rdy1 && in_tvalid) begin
      r_mag1_r <= r_mag_nxt;
      r_neg1_r <= slope_in[DW-1];
      g_mag1_r <= g_mag_nxt;
      g_neg1_r <= grad_in[DW-1];
      mode1_r  <= mode_r;
    end
  end

  // ---------------- stage 2: region select, divider operands ----------------
  logic [DW+1:0]     r_ext, r3;
  logic              lt_one, small_r, big_r;
  lim_sel_t          sel_nxt;
  logic [QW-1:0]     x_nxt;
  logic [2*QW:0]     bprod_nxt;

  lim_sel_t          sel2_r;
  logic [DW-1:0]     num2_r, den2_r, g_mag2_r;
  logic              g_neg2_r;
  logic [QW-1:0]     x2_r;
  logic [2*QW:0]     bprod2_r;

  assign r_ext   = {2'b00, r_mag1_r};
  assign r3      = r_ext + {r_mag1_r, 1'b0};
  assign lt_one  = r_ext < ONE_X;
  assign small_r = lt_one && (r3 < ONE_X);
  assign big_r   = r_ext > THREE_X;
  // 1 + 2r, only meaningful below r = 1
  assign x_nxt     = ONE_Q + QW'({r_mag1_r[FRAC_BITS-1:0], 1'b0});
  assign bprod_nxt = x_nxt * RECIP3;

  always_comb begin
    sel_nxt = LIM_ONE;
    if (r_neg1_r || r_mag1_r == '0) begin
      sel_nxt = LIM_ZERO;
    end else if (mode1_r == MODE_NO_RS) begin
      sel_nxt = lt_one ? LIM_MIN : LIM_ONE;
    end else if (small_r || big_r) begin
      sel_nxt = LIM_QUOT;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      sel2_r   <= sel_nxt;
      // 4r/(1+r) divides r, 4/(1+r) divides one; both scaled by 2^QW
      num2_r   <= big_r ? ONE_D : r_mag1_r;
      den2_r   <= ONE_D + r_mag1_r;
      g_mag2_r <= g_mag1_r;
      g_neg2_r <= g_neg1_r;
      x2_r     <= x_nxt;
      bprod2_r <= bprod_nxt;
    end
  end

  // ---------------- stage 3: (1+2r)/3 correction ----------------
  logic [LIM_W-1:0] b_est;
  logic [QW:0]      b_triple, b_rem;
  logic [LIM_W-1:0] b_nxt;

  logic [DW-1:0]     num3_r, den3_r;
  logic [SIDE_W-1:0] side3_r;

  assign b_est    = bprod2_r[RSH +: LIM_W];
  assign b_triple = {b_est, 1'b0} + {1'b0, b_est};
  assign b_rem    = {1'b0, x2_r} - b_triple;
  assign b_nxt    = (b_rem >= (QW+1)'(3)) ? b_est + 1'b1 : b_est;

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      num3_r  <= num2_r;
      den3_r  <= den2_r;
      side3_r <= {b_nxt, sel2_r, g_neg2_r, g_mag2_r};
    end
  end

  // ---------------- divider ----------------
  logic [QW-1:0]     quot;
  logic [SIDE_W-1:0] side_q;

  tvdsl_div #(
    .DATA_WIDTH (DW),
    .QUOT_WIDTH (QW),
    .SIDE_WIDTH (SIDE_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v3_r),
    .in_ready  (div_in_ready),
    .in_num    (num3_r),
    .in_den    (den3_r),
    .in_side   (side3_r),
    .out_valid (div_out_valid),
    .out_ready (rdy4),
    .out_quot  (quot),
    .out_side  (side_q)
  );

  // ---------------- stage 4: limiter select ----------------
  logic [DW-1:0]    g_mag_q;
  logic             g_neg_q;
  lim_sel_t         sel_q;
  logic [LIM_W-1:0] b_q;
  logic [QW-1:0]    cand;
  logic [LIM_W-1:0] lim_nxt;

  logic [LIM_W-1:0] lim4_r;
  logic [DW-1:0]    g_mag4_r;
  logic             g_neg4_r;

  assign g_mag_q = side_q[DW-1:0];
  assign g_neg_q = side_q[DW];
  assign sel_q   = lim_sel_t'(side_q[DW+LIM_SEL_W:DW+1]);
  assign b_q     = side_q[SIDE_W-1 -: LIM_W];

  always_comb begin
    cand = quot;
    if (sel_q == LIM_MIN && {1'b0, b_q} < quot) begin
      cand = {1'b0, b_q};
    end
    case (sel_q)
      LIM_ZERO: lim_nxt = '0;
      LIM_ONE:  lim_nxt = ONE_L;
      LIM_QUOT,
      LIM_MIN:  lim_nxt = (cand > ONE_Q) ? ONE_L : cand[LIM_W-1:0];
      default:  lim_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy4 && div_out_valid) begin
      lim4_r   <= lim_nxt;
      g_mag4_r <= g_mag_q;
      g_neg4_r <= g_neg_q;
    end
  end

  // ---------------- stage 5: split multiply ----------------
  logic [DW-HW+LIM_W-1:0] ph5_r;
  logic [HW+LIM_W-1:0]    pl5_r;
  logic [LIM_W-1:0]       lim5_r;
  logic                   g_neg5_r;

  always_ff @(posedge clk) begin
    if (rdy5 && v4_r) begin
      ph5_r    <= g_mag4_r[DW-1:HW] * lim4_r;
      pl5_r    <= g_mag4_r[HW-1:0] * lim4_r;
      lim5_r   <= lim4_r;
      g_neg5_r <= g_neg4_r;
    end
  end

  // ---------------- stage 6: sum and scale ----------------
  logic [DW+LIM_W-1:0] full_prod;

  logic [DW-1:0]    prod6_r;
  logic [LIM_W-1:0] lim6_r;
  logic             g_neg6_r;

  assign full_prod = {ph5_r, {HW{1'b0}}} + (DW+LIM_W)'(pl5_r);

  always_ff @(posedge clk) begin
    if (rdy6 && v5_r) begin
      prod6_r  <= full_prod[FRAC_BITS +: DW];
      lim6_r   <= lim5_r;
      g_neg6_r <= g_neg5_r;
    end
  end

  // ---------------- stage 7: sign and output register ----------------
  logic [DW-1:0]    grad7_r;
  logic [LIM_W-1:0] lim7_r;

  always_ff @(posedge clk) begin
    if (rdy7 && v6_r) begin
      // magnitude never exceeds the input's, so no saturation is needed
      grad7_r <= g_neg6_r ? (~prod6_r + 1'b1) : prod6_r;
      lim7_r  <= lim6_r;
    end
  end

  assign out_tvalid = v7_r;
  assign out_tdata  = OUT_W'({lim7_r, grad7_r});

`ifndef NO_ASSERTIONS
  a_div_operands: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> num2_r < den2_r)
    else $error("limiter: divider numerator not below divisor");

  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    div_out_valid && sel_q == LIM_QUOT |-> quot <= ONE_Q)
    else $error("limiter: quotient above one in a plain quotient region");

  a_lim_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> lim7_r <= ONE_L)
    else $error("limiter: limiter value above one");

  a_zero_lim: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && lim7_r == '0 |-> grad7_r == '0)
    else $error("limiter: nonzero gradient with zero limiter");
`endif

endmodule

@@ src/tvdsl_div.sv @@
// tvdsl_div: pipelined restoring divider, one quotient bit per stage, with
// a sideband word carried alongside. Low numerator bits are taken as zero.
// No package dependencies.
`timescale 1ns / 1ps

module tvdsl_div #(
  parameter int DATA_WIDTH = 32,
  parameter int QUOT_WIDTH = 18,
  parameter int SIDE_WIDTH = 52
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [DATA_WIDTH-1:0] in_num,   // must be below in_den
  input  logic [DATA_WIDTH-1:0] in_den,
  input  logic [SIDE_WIDTH-1:0] in_side,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [QUOT_WIDTH-1:0] out_quot, // floor(in_num * 2^QUOT_WIDTH / in_den)
  output logic [SIDE_WIDTH-1:0] out_side
);

  logic                  v_r    [QUOT_WIDTH];
  logic [DATA_WIDTH-1:0] rem_r  [QUOT_WIDTH];
  logic [DATA_WIDTH-1:0] den_r  [QUOT_WIDTH];
  logic [QUOT_WIDTH-1:0] quo_r  [QUOT_WIDTH];
  logic [SIDE_WIDTH-1:0] side_r [QUOT_WIDTH];
  logic                  rdy    [QUOT_WIDTH+1];

  assign rdy[QUOT_WIDTH] = out_ready;

  for (genvar i = 0; i < QUOT_WIDTH; i++) begin : g_stage
    logic                  v_in;
    logic [DATA_WIDTH-1:0] rem_in;
    logic [DATA_WIDTH-1:0] den_in;
    logic [QUOT_WIDTH-1:0] quo_in;
    logic [SIDE_WIDTH-1:0] side_in;
    logic [DATA_WIDTH:0]   trial;
    logic [DATA_WIDTH:0]   diff;
    logic                  ge;

    if (i == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = in_num;
      assign den_in  = in_den;
      assign quo_in  = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign den_in  = den_r[i-1];
      assign quo_in  = quo_r[i-1];
      assign side_in = side_r[i-1];
    end

    assign trial  = {rem_in, 1'b0};
    assign ge     = trial >= {1'b0, den_in};
    assign diff   = trial - {1'b0, den_in};
    // a stage takes new contents when empty or when its own contents move on
    assign rdy[i] = !v_r[i] || rdy[i+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (rdy[i]) begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i] && v_in) begin
        rem_r[i]  <= ge ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
        den_r[i]  <= den_in;
        quo_r[i]  <= {quo_in[QUOT_WIDTH-2:0], ge};
        side_r[i] <= side_in;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[QUOT_WIDTH-1];
  assign out_quot  = quo_r[QUOT_WIDTH-1];
  assign out_side  = side_r[QUOT_WIDTH-1];

`ifndef NO_ASSERTIONS
  // partial remainder must stay below the divisor or quotient bits are lost
  a_rem_first: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] |-> rem_r[0] < den_r[0])
    else $error("divider: first-stage remainder not below divisor");

  a_rem_last: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[QUOT_WIDTH-1] |-> rem_r[QUOT_WIDTH-1] < den_r[QUOT_WIDTH-1])
    else $error("divider: last-stage remainder not below divisor");

  a_tail_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[QUOT_WIDTH-1] && !out_ready |=>
      v_r[QUOT_WIDTH-1] && $stable(quo_r[QUOT_WIDTH-1]))
    else $error("divider: stalled quotient changed");
`endif

endmodule

@@ test/tvd_limiter_checker.sv @@
// tvd_limiter_checker: watches the in_, out_ and cfg_ channels of the slope limiter,
// predicts each result and compares it. Depends on tvdsl_pkg.
`timescale 1ns / 1ps

module tvd_limiter_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [63:0]                      in_tdata,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [55:0]                      out_tdata,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [tvdsl_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [tvdsl_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  input  logic [tvdsl_pkg::CFG_DATA_W-1:0] cfg_prdata,
  input  logic                             cfg_pready,
  output int unsigned                      fail_count,
  output int unsigned                      pending
);

  import tvdsl_pkg::*;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int LW = FB + 1;
  localparam logic [63:0] UNITY = 64'd1 << FB;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [DW-1:0] grad;
    logic [LW-1:0] phi;
  } limited_grad_t;

  limited_grad_t expected_q[$];
  limit_mode_t   mode;

  initial begin
    fail_count = 0;
    pending    = 0;
    mode       = MODE_RS_CAP;
  end

  // phi times gradient, both magnitudes truncated, sign put back afterwards
  function automatic limited_grad_t limit_gradient(logic [DW-1:0] ratio, logic [DW-1:0] grad,
                                                   limit_mode_t m);
    logic [63:0]   r_mag;
    logic [63:0]   g_mag;
    logic [63:0]   phi;
    logic [63:0]   cap;
    logic [63:0]   prod;
    logic [DW-1:0] neg_r;
    logic [DW-1:0] neg_g;
    limited_grad_t res;
    neg_r = -ratio;
    neg_g = -grad;
    r_mag = ratio[DW-1] ? {32'd0, neg_r} : {32'd0, ratio};
    g_mag = grad[DW-1] ? {32'd0, neg_g} : {32'd0, grad};
    if (ratio[DW-1] || r_mag == 0) begin
      phi = 0;
    end else if (m == MODE_NO_RS) begin
      if (r_mag >= UNITY) begin
        phi = UNITY;
      end else begin
        phi = (4 * r_mag * UNITY) / (UNITY + r_mag);
        cap = (UNITY + 2 * r_mag) / 3;
        if (cap < phi) phi = cap;
        if (phi > UNITY) phi = UNITY;
      end
    end else if (3 * r_mag < UNITY) begin
      phi = (4 * r_mag * UNITY) / (UNITY + r_mag);
    end else if (r_mag > 3 * UNITY) begin
      phi = (4 * UNITY * UNITY) / (UNITY + r_mag);
    end else begin
      phi = UNITY;
    end
    prod     = (g_mag * phi) >> FB;
    res.grad = grad[DW-1] ? -prod[DW-1:0] : prod[DW-1:0];
    res.phi  = phi[LW-1:0];
    return res;
  endfunction

  task automatic report(string what, logic [63:0] want, logic [63:0] got);
    if (fail_count < MAX_REPORTS)
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    limited_grad_t want;
    if (!rst_n) begin
      expected_q.delete();
      mode    = MODE_RS_CAP;
      pending = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          report("unexpected result", 64'd0, {8'd0, out_tdata});
        end else begin
          want = expected_q.pop_front();
          if (out_tdata[DW-1:0] !== want.grad)
            report("gradient_out", 64'(want.grad), 64'(out_tdata[DW-1:0]));
          if (out_tdata[DW+LW-1:DW] !== want.phi)
            report("limiter_value", 64'(want.phi), 64'(out_tdata[DW+LW-1:DW]));
        end
      end
      if (in_tvalid && in_tready)
        expected_q.push_back(limit_gradient(in_tdata[31:0], in_tdata[63:32], mode));
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr == ADDR_LIMIT_MODE) begin
        if (cfg_pwrite)
          mode = limit_mode_t'(cfg_pwdata[0]);
        else if (cfg_prdata !== {{(CFG_DATA_W-1){1'b0}}, mode})
          report("limit_mode readback", {63'd0, mode}, 64'(cfg_prdata));
      end
      pending = expected_q.size();
    end
  end

endmodule

@@ test/tb_tvd_slope_limiter_unit.sv @@
// tb_tvd_slope_limiter_unit: stimulus and verdict for the TVD slope limiter.
// Depends on tvdsl_pkg, tvd_slope_limiter_unit and tvd_limiter_checker.
`timescale 1ns / 1ps

module tb_tvd_slope_limiter_unit;
  import tvdsl_pkg::*;

  localparam int          PHASES      = 6;
  localparam int          PHASE_ITEMS = 205;
  localparam int          HOLD_CYCLES = 300;
  localparam int          DRAIN_WAIT  = 40;
  localparam logic [31:0] ONE_Q       = 32'h0001_0000;

  logic                  clk;
  logic                  rst_n;
  logic [63:0]           in_tdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [55:0]           out_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;
  int unsigned           fail_count;
  int unsigned           pending;

  bit quiet;
  bit stall_req;
  bit stall_done;

  tvd_slope_limiter_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  tvd_limiter_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #400_000;
    $display("tb_tvd_slope_limiter_unit NOT OK");
    $finish;
  end

  // result side: random back-pressure, plus one long hold-off on request
  initial begin
    out_tready = 1'b0;
    stall_done = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_req && !stall_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        stall_done = 1'b1;
      end
      out_tready <= quiet || ($urandom_range(99) >= 8);
    end
  end

  // entered and left at a falling edge
  task automatic send_item(logic [31:0] ratio, logic [31:0] grad);
    while (!quiet && $urandom_range(99) < 8) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {grad, ratio};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic cfg_access(logic wr, logic [CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= ADDR_LIMIT_MODE;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_mode(logic [CFG_DATA_W-1:0] data);
    cfg_access(1'b1, data);
    // the bus goes idle between the write and the readback
    @(negedge clk);
    cfg_access(1'b0, '0);
  endtask

  function automatic logic [31:0] pick_ratio();
    logic [31:0] edges[4];
    edges = '{32'h0000_5555, 32'h0000_5556, ONE_Q, 3 * ONE_Q};
    case ($urandom_range(7))
      0:       return $urandom;
      1:       return $urandom_range(1, 32'h6000);
      2:       return $urandom_range(0, 32'h4_0000);
      3:       return edges[$urandom_range(3)] - 2 + $urandom_range(4);
      4:       return {1'b1, 31'($urandom)};
      5:       return $urandom_range(32'h3_0000, 32'h7fff_ffff);
      default: return $urandom_range(0, 32'h10_0000);
    endcase
  endfunction

  function automatic logic [31:0] pick_gradient();
    case ($urandom_range(9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return $urandom_range(0, 32'h3_0000);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] dir_ratio[12];
    logic [31:0] dir_grad[12];
    logic [31:0] wdata;
    dir_ratio = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_0000, 32'h0000_0001,
                  32'h0000_5555, 32'h0000_5556, 32'h0000_8000, 32'h0001_0000,
                  32'h0003_0000, 32'h0003_0001, 32'h7fff_ffff, 32'h0000_ffff};
    dir_grad  = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'h7fff_ffff,
                  32'h8000_0000, 32'h1234_5678, 32'hffff_0000, 32'h7fff_ffff,
                  32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff};
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    quiet       = 1'b0;
    stall_req   = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed corners, once per mode, register at both extremes
    for (int m = 0; m < 2; m++) begin
      set_mode(m == 0 ? 32'h0000_0000 : 32'hffff_ffff);
      for (int i = 0; i < 12; i++) send_item(dir_ratio[i], dir_grad[i]);
      drain();
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wdata    = $urandom;
      wdata[0] = ph[0];
      set_mode(wdata);
      quiet = (ph == 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // receiver stops for a while so the pipeline backs up
        if (ph == 2 && i == 20) stall_req = 1'b1;
        send_item(pick_ratio(), pick_gradient());
      end
      drain();
    end
    quiet = 1'b0;

    if (fail_count == 0)
      $display("tb_tvd_slope_limiter_unit OK");
    else
      $display("tb_tvd_slope_limiter_unit NOT OK");
    $finish;
  end

endmodule
